// ===== hdl/gbn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types, codes and helpers of the Go-Back-N sender window.
// ----------------------------------------------------------------------------
package gbn_pkg;

    // Window and sequence sizing
    localparam int WINDOW_SIZE = 8;
    localparam int SEQ_BITS    = 16;
    localparam int MAX_PAYLOAD = 500;

    localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
    localparam int PTR_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int LEN_W = 9;

    // Input opcodes
    localparam logic [1:0] OP_DATA = 2'd0;
    localparam logic [1:0] OP_RX   = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;
    localparam logic [1:0] OP_END  = 2'd3;

    // Received packet types
    localparam logic [1:0] RX_ACK  = 2'd0;
    localparam logic [1:0] RX_DATA = 2'd1;
    localparam logic [1:0] RX_EOT  = 2'd2;

    // Result actions
    localparam logic [2:0] ACT_SEND     = 3'd0;
    localparam logic [2:0] ACT_EOT      = 3'd1;
    localparam logic [2:0] ACT_REJECT   = 3'd2;
    localparam logic [2:0] ACT_ACK      = 3'd3;
    localparam logic [2:0] ACT_IGNORE   = 3'd4;
    localparam logic [2:0] ACT_FINISHED = 3'd5;
    localparam logic [2:0] ACT_NOTHING  = 3'd6;

    // Sender phases
    localparam logic [1:0] PH_SEND  = 2'd0;
    localparam logic [1:0] PH_DRAIN = 2'd1;
    localparam logic [1:0] PH_WAIT  = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    // Input transaction
    typedef struct packed {
        logic [1:0]  opcode;
        logic [8:0]  chunk_length;
        logic [1:0]  rx_type;
        logic [15:0] rx_seq;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] seq;
        logic [8:0]  length;
        logic [3:0]  in_flight;
        logic        last;
    } result_t;

    // Classified command handed from front to back
    typedef struct packed {
        logic [1:0]       opcode;
        logic [LEN_W-1:0] length;
        logic             is_ack;
        logic             is_eot;
        logic             seq_ok;
        logic [15:0]      rx_seq;
    } cmd_t;

    // Add an offset of up to one full window to a ring pointer
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
        if (s >= (CNT_W + 1)'(WINDOW_SIZE)) begin
            s = s - (CNT_W + 1)'(WINDOW_SIZE);
        end
        return PTR_W'(s);
    endfunction

endpackage

// ===== hdl/go_back_n_sender_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_back_n_sender_window
// Go-Back-N sender window control: data, receive, tick and end events in,
// send/ack/EOT decisions out.
// ----------------------------------------------------------------------------
// Each input transaction is decoded and queued (two entries) in the front,
// then executed by the window engine, which handles one command at a time.
// Most commands yield one result; an ack that empties the window while
// draining yields two (ack, then EOT); a timeout resend yields one result
// per resent packet, after the first length is fetched from the window
// ring memory. The result register lets the engine load a new result in
// the same cycle the previous one is taken, so sustained throughput is one
// result per cycle while m_ready is held high. timeout_ticks must be
// written through cfg_wr_en/cfg_wr_data only while the block is idle; the
// block itself does not enforce this.
module go_back_n_sender_window (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  gbn_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output gbn_pkg::result_t    m_data
);

    logic          cmd_valid;
    logic          cmd_pop;
    gbn_pkg::cmd_t cmd;

    // Decode and queue incoming events
    gbn_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    // Execute commands against the window state
    gbn_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (cmd_valid),
        .cmd_pop     (cmd_pop),
        .cmd         (cmd),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

// ===== hdl/gbn_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_front
// Accepts input transactions, decodes them into commands and queues them
// for the window engine in a two-entry queue.
// ----------------------------------------------------------------------------
module gbn_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  gbn_pkg::in_item_t s_data,
    output logic             cmd_valid,
    input  logic             cmd_pop,
    output gbn_pkg::cmd_t    cmd
);

    gbn_pkg::cmd_t q_mem [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    q_cnt_reg, q_cnt_next;
    gbn_pkg::cmd_t cls;
    logic          push;
    logic          pop;

    // Decode the transaction: saturate length, classify packet type
    always_comb begin
        cls.opcode = s_data.opcode;
        if (13'(s_data.chunk_length) > 13'(gbn_pkg::MAX_PAYLOAD)) begin
            cls.length = gbn_pkg::LEN_W'(gbn_pkg::MAX_PAYLOAD);
        end else begin
            cls.length = s_data.chunk_length;
        end
        cls.is_ack = (s_data.rx_type == gbn_pkg::RX_ACK);
        cls.is_eot = (s_data.rx_type == gbn_pkg::RX_EOT);
        cls.seq_ok = ((32'(s_data.rx_seq) >> gbn_pkg::SEQ_BITS) == 32'd0);
        cls.rx_seq = s_data.rx_seq;
    end

    assign s_ready   = (q_cnt_reg != 2'd2);
    assign push      = s_valid && s_ready;
    assign cmd_valid = (q_cnt_reg != 2'd0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = q_mem[rd_ptr_reg];

    // Advance queue pointers
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        q_cnt_next  = q_cnt_reg;
        if (push && !pop) begin
            q_cnt_next = q_cnt_reg + 2'd1;
        end else if (pop && !push) begin
            q_cnt_next = q_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            q_cnt_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            q_cnt_reg  <= q_cnt_next;
        end
    end

    // Store queued commands
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== hdl/gbn_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_back
// Window engine: holds base sequence, window ring, timer and phase,
// executes one command at a time and drives the result register.
// ----------------------------------------------------------------------------
module gbn_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    input  logic                cmd_valid,
    output logic                cmd_pop,
    input  gbn_pkg::cmd_t       cmd,
    output logic                m_valid,
    input  logic                m_ready,
    output gbn_pkg::result_t    m_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EOT    = 2'd1;
    localparam logic [1:0] ST_RESEND = 2'd2;

    localparam int CW = gbn_pkg::CNT_W;
    localparam int PW = gbn_pkg::PTR_W;
    localparam int SW = gbn_pkg::SEQ_BITS;
    localparam int LW = gbn_pkg::LEN_W;

    logic [1:0]    state_reg, state_next;
    logic [1:0]    phase_reg, phase_next;
    logic [SW-1:0] base_reg, base_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] idx_reg, idx_next;
    logic [15:0]   timer_reg, timer_next;
    logic [15:0]   timeout_reg;

    logic [LW-1:0] win_len_mem [gbn_pkg::WINDOW_SIZE];
    logic [LW-1:0] rd_data_reg;
    logic          rd_en;
    logic [PW-1:0] rd_addr;
    logic          wr_en;
    logic [PW-1:0] wr_addr;

    logic             out_valid_reg;
    gbn_pkg::result_t out_reg;
    logic             out_load;
    logic             emit;
    gbn_pkg::result_t res;

    logic [SW-1:0] next_seq;
    logic [SW-1:0] off;
    logic [CW-1:0] pop_cnt;
    logic [CW-1:0] count_after;
    logic [15:0]   limit;
    logic [16:0]   timer_inc;
    logic          resend_last;

    assign out_load    = !out_valid_reg || m_ready;
    assign next_seq    = base_reg + SW'(count_reg);
    assign off         = SW'(cmd.rx_seq) - base_reg;
    assign pop_cnt     = CW'(off) + CW'(1);
    assign count_after = count_reg - pop_cnt;
    assign limit       = (timeout_reg == 16'd0) ? 16'd1 : timeout_reg;
    assign timer_inc   = 17'(timer_reg) + 17'd1;
    assign resend_last = (CW'(idx_reg) == count_reg - CW'(1));
    assign wr_addr     = gbn_pkg::ptr_add(head_reg, count_reg);

    // Execute commands and sequence multi-result bursts
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        base_next  = base_reg;
        count_next = count_reg;
        head_next  = head_reg;
        idx_next   = idx_reg;
        timer_next = timer_reg;
        cmd_pop    = 1'b0;
        emit       = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = head_reg;
        wr_en      = 1'b0;
        res        = '0;
        res.in_flight = 4'(count_reg);
        res.last      = 1'b1;

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && out_load) begin
                    cmd_pop = 1'b1;
                    emit    = 1'b1;
                    case (cmd.opcode)
                        gbn_pkg::OP_DATA: begin
                            if (phase_reg != gbn_pkg::PH_SEND) begin
                                res.action = gbn_pkg::ACT_IGNORE;
                            end else if (count_reg >= CW'(gbn_pkg::WINDOW_SIZE)) begin
                                res.action = gbn_pkg::ACT_REJECT;
                                res.seq    = 16'(next_seq);
                            end else begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                                if (count_reg == '0) begin
                                    timer_next = 16'd0;
                                end
                                res.action    = gbn_pkg::ACT_SEND;
                                res.seq       = 16'(next_seq);
                                res.length    = cmd.length;
                                res.in_flight = 4'(count_reg + CW'(1));
                            end
                        end
                        gbn_pkg::OP_RX: begin
                            timer_next = 16'd0;
                            if (phase_reg == gbn_pkg::PH_SEND
                                    || phase_reg == gbn_pkg::PH_DRAIN) begin
                                if (cmd.is_ack && cmd.seq_ok && off < SW'(count_reg)) begin
                                    count_next    = count_after;
                                    base_next     = base_reg + SW'(pop_cnt);
                                    head_next     = gbn_pkg::ptr_add(head_reg, pop_cnt);
                                    res.action    = gbn_pkg::ACT_ACK;
                                    res.seq       = cmd.rx_seq;
                                    res.in_flight = 4'(count_after);
                                    if (phase_reg == gbn_pkg::PH_DRAIN
                                            && count_after == '0) begin
                                        res.last   = 1'b0;
                                        state_next = ST_EOT;
                                    end
                                end else begin
                                    res.action = gbn_pkg::ACT_IGNORE;
                                end
                            end else if (phase_reg == gbn_pkg::PH_WAIT && cmd.is_eot) begin
                                phase_next = gbn_pkg::PH_DONE;
                                res.action = gbn_pkg::ACT_FINISHED;
                            end else begin
                                res.action = gbn_pkg::ACT_IGNORE;
                            end
                        end
                        gbn_pkg::OP_TICK: begin
                            res.action = gbn_pkg::ACT_NOTHING;
                            if ((phase_reg == gbn_pkg::PH_SEND
                                    || phase_reg == gbn_pkg::PH_DRAIN)
                                    && count_reg != '0) begin
                                if (timer_inc >= 17'(limit)) begin
                                    // Start resend: prefetch the oldest length
                                    timer_next = 16'd0;
                                    emit       = 1'b0;
                                    rd_en      = 1'b1;
                                    rd_addr    = head_reg;
                                    idx_next   = '0;
                                    state_next = ST_RESEND;
                                end else begin
                                    timer_next = 16'(timer_inc);
                                end
                            end else begin
                                timer_next = 16'd0;
                            end
                        end
                        gbn_pkg::OP_END: begin
                            if (phase_reg != gbn_pkg::PH_SEND) begin
                                res.action = gbn_pkg::ACT_IGNORE;
                            end else if (count_reg == '0) begin
                                phase_next = gbn_pkg::PH_WAIT;
                                res.action = gbn_pkg::ACT_EOT;
                                res.seq    = 16'(next_seq);
                            end else begin
                                phase_next = gbn_pkg::PH_DRAIN;
                                res.action = gbn_pkg::ACT_NOTHING;
                            end
                        end
                        default: begin
                            res.action = gbn_pkg::ACT_IGNORE;
                        end
                    endcase
                end
            end
            ST_EOT: begin
                // Window drained by the last ack: announce EOT
                if (out_load) begin
                    emit       = 1'b1;
                    res.action = gbn_pkg::ACT_EOT;
                    res.seq    = 16'(next_seq);
                    phase_next = gbn_pkg::PH_WAIT;
                    state_next = ST_IDLE;
                end
            end
            ST_RESEND: begin
                // Resend one window entry per cycle while the result slot can be loaded, fetch the next one
                if (out_load) begin
                    emit       = 1'b1;
                    res.action = gbn_pkg::ACT_SEND;
                    res.seq    = 16'(base_reg + SW'(idx_reg));
                    res.length = rd_data_reg;
                    res.last   = resend_last;
                    if (resend_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + PW'(1);
                        rd_en    = 1'b1;
                        rd_addr  = gbn_pkg::ptr_add(head_reg, CW'(idx_reg) + CW'(1));
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= gbn_pkg::PH_SEND;
            base_reg      <= '0;
            count_reg     <= '0;
            head_reg      <= '0;
            idx_reg       <= '0;
            timer_reg     <= 16'd0;
            timeout_reg   <= 16'd100;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            base_reg  <= base_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            idx_reg   <= idx_next;
            timer_reg <= timer_next;
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (emit) begin
            out_reg <= res;
        end
    end

    // Window length ring
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            win_len_mem[wr_addr] <= cmd.length;
        end
        if (rd_en) begin
            rd_data_reg <= win_len_mem[rd_addr];
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(gbn_pkg::WINDOW_SIZE))
        else $error("window count above window size");

    a_timer_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == '0 |-> timer_reg == 16'd0)
        else $error("timer running with empty window");

    a_resend_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RESEND |-> (count_reg != '0 && CW'(idx_reg) < count_reg))
        else $error("resend index outside window");

    a_eot_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EOT |-> (count_reg == '0 && phase_reg == gbn_pkg::PH_DRAIN))
        else $error("EOT pending with packets in flight");

    a_resend_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESEND && !out_load) |=> $stable(idx_reg))
        else $error("resend advanced while result slot full");

endmodule
